@@ rtl/als_pkg.sv @@
package als_pkg;

    // Coordinate format of the endpoints
    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 8;
    localparam int IN_COORD_BITS   = COORD_INT_BITS + COORD_FRAC_BITS;

    // Slope and intersection format
    localparam int SLOPE_FRAC_BITS = 16;
    localparam int SLOPE_BITS      = SLOPE_FRAC_BITS + 2;
    localparam int ACC_BITS        = 30;

    // Color format
    localparam int CHAN_BITS  = 8;
    localparam int COLOR_BITS = 3 * CHAN_BITS;

    // One quotient bit per divider step, integer bit included
    localparam int DIV_STEPS    = SLOPE_FRAC_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Stream word widths
    localparam int IN_TDATA_BITS  = 4 * IN_COORD_BITS + COLOR_BITS;
    localparam int OUT_TDATA_BITS = 4 * COORD_INT_BITS + 2 * COLOR_BITS;

    // Input selector
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic capture;     // latch the accepted word
        logic swap;        // decide steepness, swap axes
        logic order;       // order endpoints, set up line and divider
        logic div_step;    // one restoring divide step
        logic slope_write; // commit quotient as slope
        logic emit;        // produce one column into the output register
    } als_cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
    } als_status_t;

endpackage

@@ rtl/als_ctrl.sv @@
module als_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  func,
    output logic                  s_tready,
    input  als_pkg::als_status_t  status,
    output als_pkg::als_cmd_t     cmd
);
    import als_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWAP  = 3'd1;
    localparam logic [2:0] ST_ORDER = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SLOPE = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

    logic [2:0]              state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (func == FUNC_STEP) ? ST_EMIT : ST_SWAP;
                end
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_ORDER;
            end
            ST_ORDER:
            begin
                cmd.order  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE:
            begin
                cmd.slope_write = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/als_datapath.sv @@
module als_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  als_pkg::als_cmd_t                   cmd,
    output als_pkg::als_status_t                status,
    input  logic [als_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [als_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import als_pkg::*;

    localparam int DX_BITS  = IN_COORD_BITS + 1;
    localparam int REM_BITS = IN_COORD_BITS + 2;
    localparam int Q_BITS   = SLOPE_FRAC_BITS + 1;
    localparam int W_BITS   = SLOPE_FRAC_BITS + 1;
    localparam int IP_BITS  = ACC_BITS - SLOPE_FRAC_BITS;
    localparam int ACC_SHIFT = SLOPE_FRAC_BITS - COORD_FRAC_BITS;

    localparam logic signed [IN_COORD_BITS:0] TRUNC_BIAS =
        (IN_COORD_BITS + 1)'((1 << COORD_FRAC_BITS) - 1);
    localparam logic [W_BITS-1:0]     W_ONE     = W_BITS'(1) << SLOPE_FRAC_BITS;
    localparam logic [SLOPE_BITS-1:0] SLOPE_ONE = SLOPE_BITS'(1) << SLOPE_FRAC_BITS;

    function automatic logic [DX_BITS-1:0] mag(input logic signed [DX_BITS-1:0] v);
        mag = v[DX_BITS-1] ? DX_BITS'(-v) : DX_BITS'(v);
    endfunction

    function automatic logic [COORD_INT_BITS-1:0] trunc_col(
        input logic signed [IN_COORD_BITS-1:0] v);
        logic signed [IN_COORD_BITS:0] biased;
        biased = (IN_COORD_BITS + 1)'(v) + (v[IN_COORD_BITS-1] ? TRUNC_BIAS : '0);
        trunc_col = biased[COORD_FRAC_BITS +: COORD_INT_BITS];
    endfunction

    function automatic logic [COLOR_BITS-1:0] scale_color(
        input logic [COLOR_BITS-1:0] c,
        input logic [W_BITS-1:0]     w);
        logic [CHAN_BITS+W_BITS-1:0] p;
        logic [COLOR_BITS-1:0]       r;
        r = '0;
        for (int k = 0; k < 3; k++)
        begin
            p = (CHAN_BITS + W_BITS)'(c[k*CHAN_BITS +: CHAN_BITS]) *
                (CHAN_BITS + W_BITS)'(w);
            r[k*CHAN_BITS +: CHAN_BITS] = p[SLOPE_FRAC_BITS +: CHAN_BITS];
        end
        scale_color = r;
    endfunction

    // Captured load word
    logic signed [IN_COORD_BITS-1:0] in_ax_reg, in_ay_reg, in_bx_reg, in_by_reg;
    logic [COLOR_BITS-1:0]           in_color_reg;

    // Endpoints after the axis swap
    logic signed [IN_COORD_BITS-1:0] sw_ax_reg, sw_ay_reg, sw_bx_reg, sw_by_reg;

    // Divider
    logic [DX_BITS-1:0]  dx_reg;
    logic [REM_BITS-1:0] rem_reg;
    logic [Q_BITS-1:0]   q_reg;
    logic                neg_reg;
    logic                dx_zero_reg;

    // Line state
    logic                              steep_reg;
    logic signed [COORD_INT_BITS-1:0]  col_now_reg, col_end_reg;
    logic [ACC_BITS-1:0]               acc_reg;
    logic [SLOPE_BITS-1:0]             slope_reg;
    logic [COLOR_BITS-1:0]             color_reg;
    logic                              active_reg, active_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic                      out_user_reg, out_last_reg;

    // Swap stage
    logic [DX_BITS-1:0] adx_raw, ady_raw;
    logic               steep_c;

    always_comb
    begin
        adx_raw = mag(DX_BITS'(in_bx_reg) - DX_BITS'(in_ax_reg));
        ady_raw = mag(DX_BITS'(in_by_reg) - DX_BITS'(in_ay_reg));
        steep_c = ady_raw > adx_raw;
    end

    // Order stage
    logic                              flip_c;
    logic signed [IN_COORD_BITS-1:0]   o_ax, o_ay, o_bx, o_by;
    logic signed [DX_BITS-1:0]         dx_c, dy_c;
    logic signed [ACC_BITS-1:0]        ay_ext;

    always_comb
    begin
        flip_c = sw_ax_reg > sw_bx_reg;
        o_ax   = flip_c ? sw_bx_reg : sw_ax_reg;
        o_ay   = flip_c ? sw_by_reg : sw_ay_reg;
        o_bx   = flip_c ? sw_ax_reg : sw_bx_reg;
        o_by   = flip_c ? sw_ay_reg : sw_by_reg;
        dx_c   = DX_BITS'(o_bx) - DX_BITS'(o_ax);
        dy_c   = DX_BITS'(o_by) - DX_BITS'(o_ay);
        ay_ext = ACC_BITS'(o_ay);
    end

    // Divide step
    logic                ge_c;
    logic [REM_BITS-1:0] rem_sub;

    always_comb
    begin
        ge_c    = rem_reg >= REM_BITS'(dx_reg);
        rem_sub = ge_c ? (rem_reg - REM_BITS'(dx_reg)) : rem_reg;
    end

    // Column emission
    logic [IP_BITS-1:0]          ip_c;
    logic [COORD_INT_BITS-1:0]   pa_c, pb_c, col_c;
    logic [W_BITS-1:0]           w_lo, w_hi;
    logic [COLOR_BITS-1:0]       rgb_hi, rgb_lo;
    logic [COORD_INT_BITS-1:0]   up_x, up_y, lo_x, lo_y;
    logic                        last_c;
    logic [OUT_TDATA_BITS-1:0]   emit_data;

    always_comb
    begin
        ip_c   = acc_reg[ACC_BITS-1 -: IP_BITS];
        pa_c   = ip_c[COORD_INT_BITS-1:0];
        pb_c   = pa_c + 1'b1;
        col_c  = col_now_reg;
        w_lo   = W_BITS'(acc_reg[SLOPE_FRAC_BITS-1:0]);
        w_hi   = W_ONE - w_lo;
        rgb_hi = scale_color(color_reg, w_hi);
        rgb_lo = scale_color(color_reg, w_lo);
        up_x   = steep_reg ? pa_c : col_c;
        up_y   = steep_reg ? col_c : pa_c;
        lo_x   = steep_reg ? pb_c : col_c;
        lo_y   = steep_reg ? col_c : pb_c;
        last_c = col_now_reg >= col_end_reg;
        emit_data = active_reg ? {rgb_lo, lo_y, lo_x, rgb_hi, up_y, up_x} : '0;
    end

    always_comb
    begin
        status.out_free = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg && !m_tready;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        active_next = active_reg;
        if (cmd.order)
        begin
            active_next = 1'b1;
        end
        else if (cmd.emit && active_reg && last_c)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_ax_reg    <= s_tdata[0*IN_COORD_BITS +: IN_COORD_BITS];
            in_ay_reg    <= s_tdata[1*IN_COORD_BITS +: IN_COORD_BITS];
            in_bx_reg    <= s_tdata[2*IN_COORD_BITS +: IN_COORD_BITS];
            in_by_reg    <= s_tdata[3*IN_COORD_BITS +: IN_COORD_BITS];
            in_color_reg <= s_tdata[4*IN_COORD_BITS +: COLOR_BITS];
        end
        if (cmd.swap)
        begin
            steep_reg <= steep_c;
            sw_ax_reg <= steep_c ? in_ay_reg : in_ax_reg;
            sw_ay_reg <= steep_c ? in_ax_reg : in_ay_reg;
            sw_bx_reg <= steep_c ? in_by_reg : in_bx_reg;
            sw_by_reg <= steep_c ? in_bx_reg : in_by_reg;
        end
        if (cmd.order)
        begin
            dx_reg      <= DX_BITS'(dx_c);
            rem_reg     <= REM_BITS'(mag(dy_c));
            q_reg       <= '0;
            neg_reg     <= dy_c[DX_BITS-1];
            dx_zero_reg <= dx_c == '0;
            col_now_reg <= trunc_col(o_ax);
            col_end_reg <= trunc_col(o_bx);
            acc_reg     <= ACC_BITS'(ay_ext <<< ACC_SHIFT);
            color_reg   <= in_color_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[REM_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[Q_BITS-2:0], ge_c};
        end
        if (cmd.slope_write)
        begin
            if (dx_zero_reg)
            begin
                slope_reg <= SLOPE_ONE;
            end
            else if (neg_reg)
            begin
                slope_reg <= -SLOPE_BITS'(q_reg);
            end
            else
            begin
                slope_reg <= SLOPE_BITS'(q_reg);
            end
        end
        if (cmd.emit)
        begin
            out_data_reg <= emit_data;
            out_user_reg <= active_reg;
            out_last_reg <= active_reg && last_c;
            if (active_reg)
            begin
                // advance along the major axis, wrap the intersection
                acc_reg <= acc_reg + ACC_BITS'(signed'(slope_reg));
                if (!last_c)
                begin
                    col_now_reg <= col_now_reg + 1'b1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/antialiased_line_stepper_unit.sv @@
// Step word: accepted in IDLE; the EMIT state then registers the column
//   once the output register is free, and only then is a new word taken.
// Load word: swap, order, divide and slope commit in turn, the restoring
//   divider forming one slope bit per cycle; no result, no new word meanwhile.
// Reset (rst_n low, asynchronous): controller idle, no line, output empty.
module antialiased_line_stepper_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, lowest bit up: start_x[19:0], start_y[39:20], end_x[59:40],
    //   end_y[79:60], line_color[103:80]
    input  logic [als_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    // tuser: func[0] (0 load a line, 1 step one column)
    input  logic                                s_tuser,
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, lowest bit up: upper_px[11:0], upper_py[23:12], upper_rgb[47:24],
    //   lower_px[59:48], lower_py[71:60], lower_rgb[95:72]
    output logic [als_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    // tuser: pixels_valid[0]
    output logic                                m_tuser,
    // tlast: last_column
    output logic                                m_tlast
);
    import als_pkg::*;

    als_cmd_t    cmd;
    als_status_t status;

    // Sequence each word: loads run swap, order, divide and slope commit;
    // steps wait for a free output register, then emit one column.
    als_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold line state, divide for the slope, weight the two covering pixels
    // and keep the finished word in the output register until it is taken.
    als_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import als_pkg::*;

    // One input word as the sender sees it, plus its pacing
    typedef struct {
        logic                            func;
        logic signed [IN_COORD_BITS-1:0] sx;
        logic signed [IN_COORD_BITS-1:0] sy;
        logic signed [IN_COORD_BITS-1:0] ex;
        logic signed [IN_COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0]           color;
        int                              gap;     // idle cycles before the word is offered
        bit                              drain;   // offer only once no pixels are outstanding
    } line_cmd_t;

    // One column of two covering pixels
    typedef struct {
        logic signed [COORD_INT_BITS-1:0] upper_px;
        logic signed [COORD_INT_BITS-1:0] upper_py;
        logic [COLOR_BITS-1:0]            upper_rgb;
        logic signed [COORD_INT_BITS-1:0] lower_px;
        logic signed [COORD_INT_BITS-1:0] lower_py;
        logic [COLOR_BITS-1:0]            lower_rgb;
        logic                             pixels_valid;
        logic                             last_column;
    } pixel_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      s_tuser = FUNC_LOAD;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;

    antialiased_line_stepper_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Line state mirror: updated once per accepted input word
    // ------------------------------------------------------------------
    logic                             ln_steep  = 1'b0;
    logic signed [COORD_INT_BITS-1:0] ln_col    = '0;
    logic signed [COORD_INT_BITS-1:0] ln_col_end = '0;
    logic signed [ACC_BITS-1:0]       ln_acc    = '0;
    logic signed [SLOPE_BITS-1:0]     ln_slope  = '0;
    logic [COLOR_BITS-1:0]            ln_color  = '0;
    bit                               ln_active = 1'b0;

    line_cmd_t   cmd_q[$];     // words still to be sent
    pixel_pair_t pair_q[$];    // columns predicted but not yet received
    int          cmd_cnt = 0;
    int          err_cnt = 0;
    int          pairs_seen = 0;

    // Scale every channel by a weight with SLOPE_FRAC_BITS fraction bits
    function automatic logic [COLOR_BITS-1:0] shade(logic [COLOR_BITS-1:0] c,
                                                      logic [SLOPE_FRAC_BITS:0] w);
        logic [CHAN_BITS+SLOPE_FRAC_BITS:0] p;
        logic [COLOR_BITS-1:0]              res;
        for (int k = 0; k < 3; k++)
        begin
            p = c[k*CHAN_BITS +: CHAN_BITS] * w;
            res[k*CHAN_BITS +: CHAN_BITS] = p[SLOPE_FRAC_BITS +: CHAN_BITS];
        end
        return res;
    endfunction

    // Set up a new line: steepness, axis swap, endpoint order, slope
    task automatic take_line(line_cmd_t c);
        longint ax, ay, bx, by, t, dx, dy, adx, ady, q;
        ax = c.sx;
        ay = c.sy;
        bx = c.ex;
        by = c.ey;
        adx = (bx - ax) < 0 ? ax - bx : bx - ax;
        ady = (by - ay) < 0 ? ay - by : by - ay;
        ln_steep = ady > adx;
        if (ln_steep)
        begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        if (dx == 0)
            q = longint'(1) << SLOPE_FRAC_BITS;
        else
        begin
            q = ((dy < 0 ? -dy : dy) << SLOPE_FRAC_BITS) / dx;
            if (dy < 0)
                q = -q;
        end
        ln_slope = q[SLOPE_BITS-1:0];
        // Integer division truncates toward zero, as the column bounds need
        t = ax / (longint'(1) << COORD_FRAC_BITS);
        ln_col = t[COORD_INT_BITS-1:0];
        t = bx / (longint'(1) << COORD_FRAC_BITS);
        ln_col_end = t[COORD_INT_BITS-1:0];
        t = ay * (longint'(1) << (SLOPE_FRAC_BITS - COORD_FRAC_BITS));
        ln_acc = t[ACC_BITS-1:0];
        ln_color = c.color;
        ln_active = 1'b1;
    endtask

    // Produce the next column and advance the intersection
    task automatic take_step();
        pixel_pair_t                                  r;
        logic signed [ACC_BITS-SLOPE_FRAC_BITS-1:0]   ip;
        logic signed [ACC_BITS-SLOPE_FRAC_BITS-1:0]   ip_next;
        logic [SLOPE_FRAC_BITS-1:0]                   frac;
        logic                                         last;
        r = '{default: '0};
        if (ln_active)
        begin
            ip = (ACC_BITS-SLOPE_FRAC_BITS)'(ln_acc >>> SLOPE_FRAC_BITS);
            ip_next = ip + 1'b1;
            frac = ln_acc[SLOPE_FRAC_BITS-1:0];
            if (ln_steep)
            begin
                r.upper_px = ip[COORD_INT_BITS-1:0];
                r.upper_py = ln_col;
                r.lower_px = ip_next[COORD_INT_BITS-1:0];
                r.lower_py = ln_col;
            end
            else
            begin
                r.upper_px = ln_col;
                r.upper_py = ip[COORD_INT_BITS-1:0];
                r.lower_px = ln_col;
                r.lower_py = ip_next[COORD_INT_BITS-1:0];
            end
            r.upper_rgb = shade(ln_color,
                                (SLOPE_FRAC_BITS+1)'((1 << SLOPE_FRAC_BITS) - frac));
            r.lower_rgb = shade(ln_color, {1'b0, frac});
            r.pixels_valid = 1'b1;
            last = ln_col >= ln_col_end;
            r.last_column = last;
            ln_acc = ln_acc + ln_slope;
            if (last)
                ln_active = 1'b0;
            else
                ln_col = ln_col + 1'b1;
        end
        pair_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic func, int sx, int sy, int ex, int ey, int color);
        line_cmd_t c;
        c.func  = func;
        c.sx    = sx[IN_COORD_BITS-1:0];
        c.sy    = sy[IN_COORD_BITS-1:0];
        c.ex    = ex[IN_COORD_BITS-1:0];
        c.ey    = ey[IN_COORD_BITS-1:0];
        c.color = color[COLOR_BITS-1:0];
        // Every fourth stretch of 90 words goes out back to back
        c.gap   = ((cmd_cnt / 90) % 4 == 1) ? 0 : $urandom_range(0, 5);
        // Twice in the run, let the pipe empty completely before going on
        c.drain = (cmd_cnt == 700) || (cmd_cnt == 1100);
        cmd_q.push_back(c);
        cmd_cnt++;
    endtask

    task automatic queue_steps(int n);
        for (int k = 0; k < n; k++)
            queue_cmd(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // A line a few columns long anywhere in the coordinate space
    task automatic queue_short_line();
        int bx, by;
        bx = $urandom;
        by = $urandom;
        queue_cmd(FUNC_LOAD, bx, by,
                  bx + $urandom_range(0, 6000) - 3000,
                  by + $urandom_range(0, 6000) - 3000, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer words from cmd_q, mirror each accepted one
    // ------------------------------------------------------------------
    line_cmd_t cur;
    bit        have_cur = 1'b0;
    int        tx_wait  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= FUNC_LOAD;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (cur.func == FUNC_LOAD)
                    take_line(cur);
                else
                    take_step();
                have_cur = 1'b0;
            end
            if (!have_cur && cmd_q.size() > 0)
            begin
                cur = cmd_q.pop_front();
                have_cur = 1'b1;
                tx_wait = cur.gap;
            end
            // Hold a word that is not yet taken; otherwise count down the gap
            if (s_tvalid && !s_tready)
                offer = 1'b1;
            else if (!have_cur)
                offer = 1'b0;
            else if (tx_wait > 0)
            begin
                tx_wait--;
                offer = 1'b0;
            end
            else if (cur.drain && pair_q.size() != 0)
                offer = 1'b0;
            else
                offer = 1'b1;
            s_tvalid <= offer;
            if (offer)
            begin
                s_tdata <= {cur.color, cur.ey, cur.ex, cur.sy, cur.sx};
                s_tuser <= cur.func;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pace m_tready, compare each column with the oldest prediction
    // ------------------------------------------------------------------
    int rx_wait = 0;

    always @(posedge clk or negedge rst_n)
    begin
        pixel_pair_t exp_p;
        int          w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (pair_q.size() == 0)
            begin
                $error("column word with no prediction pending: %h", m_tdata);
                err_cnt++;
            end
            else
            begin
                exp_p = pair_q.pop_front();
                if (m_tdata[11:0] !== exp_p.upper_px)
                begin
                    $error("upper_px: expected %0d, got %0d", exp_p.upper_px,
                           $signed(m_tdata[11:0]));
                    err_cnt++;
                end
                if (m_tdata[23:12] !== exp_p.upper_py)
                begin
                    $error("upper_py: expected %0d, got %0d", exp_p.upper_py,
                           $signed(m_tdata[23:12]));
                    err_cnt++;
                end
                if (m_tdata[47:24] !== exp_p.upper_rgb)
                begin
                    $error("upper_rgb: expected %h, got %h", exp_p.upper_rgb, m_tdata[47:24]);
                    err_cnt++;
                end
                if (m_tdata[59:48] !== exp_p.lower_px)
                begin
                    $error("lower_px: expected %0d, got %0d", exp_p.lower_px,
                           $signed(m_tdata[59:48]));
                    err_cnt++;
                end
                if (m_tdata[71:60] !== exp_p.lower_py)
                begin
                    $error("lower_py: expected %0d, got %0d", exp_p.lower_py,
                           $signed(m_tdata[71:60]));
                    err_cnt++;
                end
                if (m_tdata[95:72] !== exp_p.lower_rgb)
                begin
                    $error("lower_rgb: expected %h, got %h", exp_p.lower_rgb, m_tdata[95:72]);
                    err_cnt++;
                end
                if (m_tuser !== exp_p.pixels_valid)
                begin
                    $error("pixels_valid: expected %b, got %b", exp_p.pixels_valid, m_tuser);
                    err_cnt++;
                end
                if (m_tlast !== exp_p.last_column)
                begin
                    $error("last_column: expected %b, got %b", exp_p.last_column, m_tlast);
                    err_cnt++;
                end
            end
            pairs_seen++;
            // Long hold-off once, so the block backs up and stalls its input;
            // every third stretch of 64 columns drains with no stalls at all
            if (pairs_seen == 150)
                w = 400;
            else if ((pairs_seen / 64) % 3 == 0)
                w = 0;
            else
                w = $urandom_range(0, 5);
            rx_wait = w;
            m_tready <= (w == 0);
        end
        else if (!m_tready)
        begin
            if (rx_wait <= 1)
            begin
                rx_wait = 0;
                m_tready <= 1'b1;
            end
            else
                rx_wait--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int r;

        // Step with no line: all-zero column
        queue_steps(1);
        // Zero length: one column with slope 1.0, then no line again
        queue_cmd(FUNC_LOAD, 768, 1280, 768, 1280, 'hFFFFFF);
        queue_steps(2);
        // Shallow line with fractional end, stepped short of its last column
        queue_cmd(FUNC_LOAD, 0, 64, 1408, 800, 'h123456);
        queue_steps(4);
        // Endpoints in reverse order, falling slope
        queue_cmd(FUNC_LOAD, 2752, 832, 640, 1536, 'hFF00FF);
        queue_steps(3);
        // Steep line with negative, reversed coordinates
        queue_cmd(FUNC_LOAD, -845, -256, -1024, -5120, 'h00FF00);
        queue_steps(2);
        // 45 degrees stays shallow
        queue_cmd(FUNC_LOAD, 0, 0, 1024, 1024, 'h0000FF);
        queue_steps(2);
        // Full-range extremes; pixel y at the top wraps for the neighbor
        queue_cmd(FUNC_LOAD, -524288, 524287, 524287, 524287, 'h000000);
        queue_steps(1);
        // Replace the active line: vertical at the extremes
        queue_cmd(FUNC_LOAD, 524287, 524287, 524287, -524288, 'hFFFFFF);
        queue_steps(2);

        // Random part: mostly short lines stepped short of, to or past their end
        while (cmd_cnt < 1450)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                queue_short_line();
                queue_steps($urandom_range(1, 14));
            end
            else if (r == 7)
            begin
                queue_cmd(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
                queue_steps($urandom_range(1, 4));
            end
            else if (r == 8)
                queue_steps($urandom_range(1, 3));
            else
            begin
                // Reload, often before the first line is stepped out
                queue_short_line();
                queue_steps($urandom_range(0, 2));
                queue_short_line();
                queue_steps($urandom_range(1, 4));
            end
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every word is taken and every column is back
        while (cmd_q.size() != 0 || have_cur || s_tvalid)
            @(posedge clk);
        while (pair_q.size() != 0)
            @(posedge clk);
        // Let a trailing load finish its divide before stopping
        repeat (40) @(posedge clk);

        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #500us;
        $display("tb_top: errors");
        $finish;
    end

endmodule
